// File: rtl/ifla_pkg.sv
// ----------------------------------------------------------------------------
// ifla_pkg
// Shared types and constants for the indexed free-list slot allocator.
// ----------------------------------------------------------------------------
package ifla_pkg;

	localparam int CAPACITY    = 256;
	localparam int VALUE_WIDTH = 32;
	localparam int SLOT_W      = $clog2(CAPACITY);
	localparam int COUNT_W     = SLOT_W + 1;

	// stream payload widths, fields packed from bit 0 and padded to bytes
	localparam int S_DATA_W = ((SLOT_W + VALUE_WIDTH + 7) / 8) * 8;
	localparam int M_DATA_W = ((SLOT_W + VALUE_WIDTH + COUNT_W + 7) / 8) * 8;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_ERASE  = 2'd1,
		MODE_READ   = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_FINISH
	} ctl_state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;  // take the request and issue memory accesses
		logic load;    // finish the request and fill the output register
	} ifla_cmd_t;

	// next-free link with its end-of-chain mark
	typedef struct packed {
		logic              last;
		logic [SLOT_W-1:0] next;
	} link_t;

endpackage

// File: rtl/ifla_ctrl.sv
// ----------------------------------------------------------------------------
// ifla_ctrl
// Two-state sequencer: accept a request, then finish it into the output
// register once that register is free.
// ----------------------------------------------------------------------------
module ifla_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output ifla_pkg::ifla_cmd_t cmd
);
	import ifla_pkg::*;

	ctl_state_t state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd.accept = 1'b0;
		cmd.load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> !in_ready && !cmd.accept)
		else $error("request accepted while another is in flight");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> out_valid)
		else $error("finished result not presented");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !(out_valid && !out_ready))
		else $error("output register overwritten while stalled");

endmodule

// File: rtl/ifla_datapath.sv
// ----------------------------------------------------------------------------
// ifla_datapath
// Value and link memories, free-chain head, high-water mark and the
// output payload register.
// ----------------------------------------------------------------------------
module ifla_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ifla_pkg::ifla_cmd_t                 cmd,
	input  ifla_pkg::mode_t                     in_mode,
	input  logic [ifla_pkg::SLOT_W-1:0]         in_slot,
	input  logic [ifla_pkg::VALUE_WIDTH-1:0]    in_value,
	output logic [ifla_pkg::SLOT_W-1:0]         out_slot,
	output logic [ifla_pkg::VALUE_WIDTH-1:0]    out_value,
	output ifla_pkg::status_t                   out_status,
	output logic [ifla_pkg::COUNT_W-1:0]        out_count
);
	import ifla_pkg::*;

	logic [VALUE_WIDTH-1:0] value_mem [CAPACITY];
	link_t                  link_mem  [CAPACITY];

	logic [SLOT_W-1:0]      head_q;
	logic                   chain_q;
	logic [COUNT_W-1:0]     hw_q;

	// request held between accept and finish
	mode_t                  mode_s1;
	logic [SLOT_W-1:0]      slot_s1;
	status_t                status_s1;
	logic                   take_s1;
	logic [VALUE_WIDTH-1:0] value_rd_s1;
	link_t                  link_rd_s1;

	logic [SLOT_W-1:0]      out_slot_q;
	logic [VALUE_WIDTH-1:0] out_value_q;
	status_t                out_status_q;
	logic [COUNT_W-1:0]     out_count_q;

	logic                   is_full;
	logic                   in_range;
	logic                   from_chain;
	logic                   fresh;
	logic                   val_we;
	logic [SLOT_W-1:0]      val_addr;
	logic                   link_we;
	logic [SLOT_W-1:0]      link_addr;
	link_t                  link_wdata;
	logic [SLOT_W-1:0]      slot_d;
	status_t                status_d;

	assign is_full    = (hw_q == COUNT_W'(CAPACITY));
	assign in_range   = ({1'b0, in_slot} < hw_q);
	assign from_chain = chain_q;
	assign fresh      = !chain_q && !is_full;

	always_comb begin
		val_we          = 1'b0;
		val_addr        = in_slot;
		link_we         = 1'b0;
		link_addr       = head_q;
		link_wdata.last = !chain_q;
		link_wdata.next = head_q;
		slot_d          = in_slot;
		status_d        = STAT_OK;
		unique case (in_mode)
			MODE_INSERT: begin
				val_addr = from_chain ? head_q : hw_q[SLOT_W-1:0];
				val_we   = cmd.accept && (from_chain || fresh);
				if (from_chain) begin
					slot_d = head_q;
				end else if (fresh) begin
					slot_d = hw_q[SLOT_W-1:0];
				end else begin
					slot_d   = '0;
					status_d = STAT_FULL;
				end
			end
			MODE_ERASE: begin
				link_addr = in_slot;
				link_we   = cmd.accept && in_range;
				if (!in_range) begin
					status_d = STAT_RANGE;
				end
			end
			MODE_READ: begin
				if (!in_range) begin
					status_d = STAT_RANGE;
				end
			end
			MODE_CLEAR: begin
				slot_d = '0;
			end
			default: status_d = STAT_OK;
		endcase
	end

	// single-ported memories with registered read data
	always_ff @(posedge clk) begin
		if (val_we) begin
			value_mem[val_addr] <= in_value;
		end
		if (cmd.accept) begin
			value_rd_s1 <= value_mem[val_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_addr] <= link_wdata;
		end
		if (cmd.accept) begin
			link_rd_s1 <= link_mem[link_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_s1   <= in_mode;
			slot_s1   <= slot_d;
			status_s1 <= status_d;
			take_s1   <= (in_mode == MODE_INSERT) && from_chain;
		end
	end

	// erase, clear and a fresh insert act at accept; an insert off the chain advances
	// the head at finish, once the link read has returned
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			chain_q <= 1'b0;
			hw_q    <= '0;
		end else if (cmd.accept) begin
			case (in_mode)
				MODE_INSERT: begin
					if (fresh) begin
						hw_q <= hw_q + COUNT_W'(1);
					end
				end
				MODE_ERASE: begin
					if (in_range) begin
						head_q  <= in_slot;
						chain_q <= 1'b1;
					end
				end
				MODE_CLEAR: begin
					head_q  <= '0;
					chain_q <= 1'b0;
					hw_q    <= '0;
				end
				default: ;
			endcase
		end else if (cmd.load && take_s1) begin
			head_q  <= link_rd_s1.next;
			chain_q <= !link_rd_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_slot_q   <= slot_s1;
			out_value_q  <= (mode_s1 == MODE_READ && status_s1 == STAT_OK) ?
			                value_rd_s1 : '0;
			out_status_q <= status_s1;
			out_count_q  <= hw_q;
		end
	end

	assign out_slot   = out_slot_q;
	assign out_value  = out_value_q;
	assign out_status = out_status_q;
	assign out_count  = out_count_q;

	a_hw_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hw_q <= COUNT_W'(CAPACITY))
		else $error("high-water mark beyond capacity");

	a_erase_links: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && in_mode == MODE_ERASE && in_range |=> chain_q && head_q == $past(in_slot))
		else $error("erased slot not at chain head");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && in_mode == MODE_CLEAR |=> !chain_q && hw_q == '0)
		else $error("clear left slots in use");

endmodule

// File: rtl/indexed_free_list_allocator.sv
// ----------------------------------------------------------------------------
// indexed_free_list_allocator
// Slot allocator with element storage: insert, erase, read and clear over a
// free chain of erased slots and a high-water mark.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata (low bit up)                         | tuser
//  --------+-----+--------------------------------------------+--------------
//  s_*     | in  | slot_index[7:0], element_value[39:8]       | mode[1:0]
//  m_*     | out | result_slot[7:0], read_value[39:8],        | status[1:0]
//          |     | slot_count[48:40]                          |
//
//  Each request is accepted in the idle state, which issues the memory
//  accesses, and is finished into the output register from the finish state.
//  The pace is set by the synchronous link-memory read on insert: the next
//  chain head comes from registered read data after the head slot is taken.
//  A result waiting in the output register does not block the next accept;
//  only finishing a second request waits for that register to be taken.
//  Reset clears the chain and high-water mark; the memories are not cleared.
//
module indexed_free_list_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ifla_pkg::S_DATA_W-1:0] s_tdata,  // slot_index, element_value
	input  logic [1:0]                    s_tuser,  // mode
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ifla_pkg::M_DATA_W-1:0] m_tdata,  // result_slot, read_value, slot_count
	output logic [1:0]                    m_tuser   // status
);
	import ifla_pkg::*;

	ifla_cmd_t              cmd;
	mode_t                  in_mode;
	logic [SLOT_W-1:0]      in_slot;
	logic [VALUE_WIDTH-1:0] in_value;
	logic [SLOT_W-1:0]      out_slot;
	logic [VALUE_WIDTH-1:0] out_value;
	status_t                out_status;
	logic [COUNT_W-1:0]     out_count;

	// unpack the incoming transfer
	assign in_mode  = mode_t'(s_tuser);
	assign in_slot  = s_tdata[SLOT_W-1:0];
	assign in_value = s_tdata[SLOT_W +: VALUE_WIDTH];

	ifla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	ifla_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_mode    (in_mode),
		.in_slot    (in_slot),
		.in_value   (in_value),
		.out_slot   (out_slot),
		.out_value  (out_value),
		.out_status (out_status),
		.out_count  (out_count)
	);

	// pack the outgoing transfer, pad bits held at zero
	assign m_tdata = M_DATA_W'({out_count, out_value, out_slot});
	assign m_tuser = out_status;

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the indexed free-list slot allocator. A behavioural
// copy of the allocator predicts the reply to every accepted request. A
// checker compares each reply transfer, field by field, with the oldest
// prediction. Stimulus: a directed pass over edge values and the special
// cases, a fill to capacity, then randomised phases with and without idling
// on either side. A closing phase holds the reply side off for a long
// stretch so that the block backs up onto its request side.
// ----------------------------------------------------------------------------
module tb;
	import ifla_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 8;
	localparam int SHOW_LIMIT  = 10;

	// one reply as the block should produce it
	typedef struct packed {
		logic [SLOT_W-1:0]      slot;
		logic [VALUE_WIDTH-1:0] value;
		status_t                status;
		logic [COUNT_W-1:0]     count;
	} alloc_reply_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;  // slot_index, element_value
	logic [1:0]          s_tuser  = MODE_INSERT;  // mode
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;  // result_slot, read_value, slot_count
	logic [1:0]          m_tuser;  // status

	indexed_free_list_allocator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Behavioural copy of the allocator state
	// ------------------------------------------------------------------
	logic [VALUE_WIDTH-1:0] elem_mem  [CAPACITY];
	logic [SLOT_W-1:0]      link_next [CAPACITY];
	bit                     link_last [CAPACITY];
	logic [SLOT_W-1:0]      chain_head = '0;
	bit                     chain_ok   = 1'b0;
	logic [COUNT_W-1:0]     high_water = '0;

	// slots holding a value that has not been erased since; used to keep
	// most erases well formed so that the chain stays free of loops
	bit slot_live [CAPACITY];

	alloc_reply_t owed_replies [$];

	int          send_idle_pct = 0;
	int          stall_pct     = 0;
	int unsigned hold_left     = 0;
	int unsigned cycle_count   = 0;
	int          fail_count    = 0;

	alloc_reply_t want;
	alloc_reply_t got;

	// Apply one request to the state copy and return the reply it owes.
	function automatic alloc_reply_t alloc_step(mode_t mode, logic [SLOT_W-1:0] idx,
			logic [VALUE_WIDTH-1:0] val);
		alloc_reply_t r;
		logic [SLOT_W-1:0] s;
		r.slot   = idx;
		r.value  = '0;
		r.status = STAT_OK;
		case (mode)
			MODE_INSERT: begin
				r.slot = '0;
				if (chain_ok) begin
					// reuse the head of the free chain and advance it
					s           = chain_head;
					elem_mem[s] = val;
					chain_ok    = !link_last[s];
					chain_head  = link_next[s];
					r.slot      = s;
				end else if (high_water < CAPACITY) begin
					s           = high_water[SLOT_W-1:0];
					elem_mem[s] = val;
					r.slot      = s;
					high_water  = high_water + COUNT_W'(1);
				end else begin
					r.status = STAT_FULL;
				end
			end
			MODE_ERASE, MODE_READ: begin
				if (idx >= high_water) begin
					r.status = STAT_RANGE;
				end else if (mode == MODE_ERASE) begin
					// push onto the chain; a repeated erase is linked again as is
					link_next[idx] = chain_head;
					link_last[idx] = !chain_ok;
					chain_head     = idx;
					chain_ok       = 1'b1;
				end else begin
					r.value = elem_mem[idx];
				end
			end
			default: begin
				// clear: drop the chain and the high-water mark, keep contents
				r.slot     = '0;
				high_water = '0;
				chain_head = '0;
				chain_ok   = 1'b0;
			end
		endcase
		r.count = high_water;
		return r;
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= SHOW_LIMIT)
			$display("%s", msg);
	endtask

	// ------------------------------------------------------------------
	// Request side: offer one transfer, hold it until taken, then predict
	// ------------------------------------------------------------------
	task automatic send_req(input mode_t mode, input logic [SLOT_W-1:0] idx,
			input logic [VALUE_WIDTH-1:0] val);
		alloc_reply_t r;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_DATA_W'({val, idx});
		s_tuser  <= mode;
		do
			@(posedge clk);
		while (!s_tready);
		// transfer taken at this edge
		r = alloc_step(mode, idx, val);
		owed_replies = {owed_replies, r};
		if (r.status == STAT_OK) begin
			case (mode)
				MODE_INSERT: slot_live[r.slot] = 1'b1;
				MODE_ERASE:  slot_live[idx] = 1'b0;
				MODE_CLEAR: begin
					foreach (slot_live[i])
						slot_live[i] = 1'b0;
				end
				default: ;
			endcase
		end
	endtask

	// Well-formed traffic with random content, plus some noise.
	task automatic send_random_req();
		int pick;
		int start;
		int j;
		int hw;
		mode_t mode;
		logic [SLOT_W-1:0] idx;
		logic [VALUE_WIDTH-1:0] val;
		pick = $urandom_range(0, 99);
		hw   = int'(high_water);
		idx  = SLOT_W'($urandom_range(0, CAPACITY - 1));
		val  = $urandom;
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 3))
				0:       val = '0;
				1:       val = '1;
				2:       val = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
				default: val = 1;
			endcase
		end
		if (pick < 45) begin
			mode = MODE_INSERT;
		end else if (pick < 72) begin
			mode = MODE_ERASE;
			if (pick < 70 && hw != 0) begin
				// prefer a live slot; fall back to any index below the mark
				idx   = SLOT_W'($urandom_range(0, hw - 1));
				start = int'(idx);
				for (int k = 0; k < hw; k++) begin
					j = (start + k) % hw;
					if (slot_live[j]) begin
						idx = SLOT_W'(j);
						break;
					end
				end
			end
		end else if (pick < 99) begin
			mode = MODE_READ;
			if (hw != 0 && $urandom_range(0, 9) != 0)
				idx = SLOT_W'($urandom_range(0, hw - 1));
		end else begin
			mode = MODE_CLEAR;
		end
		send_req(mode, idx, val);
	endtask

	// Lower valid and wait for every owed reply.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (owed_replies.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_directed();
		// out of range on an empty store, lowest and highest index
		send_req(MODE_READ, 8'd0, '0);
		send_req(MODE_ERASE, 8'd255, '1);
		// fresh slots with edge values
		send_req(MODE_INSERT, 8'd0, 32'h0000_0000);
		send_req(MODE_INSERT, 8'd255, 32'hFFFF_FFFF);
		send_req(MODE_INSERT, 8'd7, 32'hA5A5_A5A5);
		send_req(MODE_INSERT, 8'd0, 32'h5A5A_5A5A);
		send_req(MODE_READ, 8'd0, '0);
		send_req(MODE_READ, 8'd1, '0);
		send_req(MODE_READ, 8'd3, '1);
		send_req(MODE_READ, 8'd4, '0);
		send_req(MODE_READ, 8'd255, '0);
		// chain reuse, last in first out, then back to fresh slots
		send_req(MODE_ERASE, 8'd1, '0);
		send_req(MODE_ERASE, 8'd3, '0);
		send_req(MODE_INSERT, 8'd0, 32'h1234_5678);
		send_req(MODE_INSERT, 8'd0, 32'h8000_0001);
		send_req(MODE_INSERT, 8'd0, 32'h0000_0001);
		// double erase loops the chain onto one slot
		send_req(MODE_ERASE, 8'd2, '0);
		send_req(MODE_ERASE, 8'd2, '0);
		send_req(MODE_INSERT, 8'd0, 32'hCAFE_0001);
		send_req(MODE_INSERT, 8'd0, 32'hCAFE_0002);
		send_req(MODE_READ, 8'd2, '0);
		// clear: nothing in range until slots are taken again
		send_req(MODE_CLEAR, 8'd9, '1);
		send_req(MODE_READ, 8'd0, '0);
		send_req(MODE_INSERT, 8'd0, 32'h0BAD_F00D);
		send_req(MODE_READ, 8'd0, '0);
	endtask

	task automatic test_fill();
		send_req(MODE_CLEAR, 8'd0, '0);
		repeat (CAPACITY)
			send_req(MODE_INSERT, SLOT_W'($urandom), $urandom);
		// full with an empty chain
		send_req(MODE_INSERT, 8'd0, '1);
		send_req(MODE_INSERT, 8'd0, '0);
		send_req(MODE_READ, 8'd255, '0);
		send_req(MODE_READ, 8'd0, '0);
		send_req(MODE_ERASE, 8'd0, '0);
		send_req(MODE_ERASE, 8'd255, '0);
		send_req(MODE_INSERT, 8'd0, 32'h7FFF_FFFF);
		send_req(MODE_INSERT, 8'd0, 32'hFFFF_FFFE);
		send_req(MODE_INSERT, 8'd0, 32'h1);
		send_req(MODE_READ, 8'd255, '0);
		send_req(MODE_CLEAR, 8'd0, '0);
	endtask

	task automatic test_random(input int n_items, input int idle_pct, input int stall);
		send_idle_pct <= idle_pct;
		stall_pct     <= stall;
		repeat (n_items)
			send_random_req();
	endtask

	// Hold the reply side off while requests keep coming, so the block
	// fills its output and stops taking requests.
	task automatic test_backpressure();
		send_idle_pct <= 0;
		stall_pct     <= 0;
		@(negedge clk);
		hold_left = 200;
		@(posedge clk);
		repeat (60)
			send_random_req();
	endtask

	// ------------------------------------------------------------------
	// Reply side: random stalls, and the long hold-off when asked
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Check each reply transfer against the oldest owed reply.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.slot   = m_tdata[0 +: SLOT_W];
			got.value  = m_tdata[SLOT_W +: VALUE_WIDTH];
			got.count  = m_tdata[SLOT_W + VALUE_WIDTH +: COUNT_W];
			got.status = status_t'(m_tuser);
			if (owed_replies.size() == 0) begin
				note_failure($sformatf(
					"tb: unexpected reply slot %0d value %h status %0d count %0d",
					got.slot, got.value, m_tuser, got.count));
			end else begin
				want = owed_replies.pop_front();
				if (got.slot !== want.slot || got.value !== want.value
						|| m_tuser !== want.status || got.count !== want.count)
					note_failure({
						$sformatf("tb: mismatch at %0t exp slot %0d value %h ",
							$realtime, want.slot, want.value),
						$sformatf("status %0d count %0d, ", want.status, want.count),
						$sformatf("got slot %0d value %h status %0d count %0d",
							got.slot, got.value, m_tuser, got.count)});
			end
		end
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill();
		test_random(390, 0, 0);
		test_random(390, 71, 0);
		test_random(390, 0, 71);
		test_random(390, 32, 32);
		test_backpressure();

		drain();
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (owed_replies.size() != 0)
			note_failure($sformatf("tb: %0d replies never arrived", owed_replies.size()));

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
